>>> hw/rtl/mersenne_twister_uniform_top_defines.svh
// Assertion macros used by the port-level checker.
`ifndef MERSENNE_TWISTER_UNIFORM_TOP_DEFINES_SVH
`define MERSENNE_TWISTER_UNIFORM_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define MTU_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define MTU_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

>>> hw/rtl/mtu_pkg.sv
package mtu_pkg;

  localparam int unsigned STATE_WORDS  = 624;
  localparam int unsigned SHIFT_OFFSET = 397;
  localparam int unsigned IDX_W        = 10;
  localparam int unsigned WORD_W       = 32;

  localparam logic [WORD_W-1:0] MATRIX_A = 32'h9908_B0DF;
  localparam logic [WORD_W-1:0] TEMPER_B = 32'h9D2C_5680;
  localparam logic [WORD_W-1:0] TEMPER_C = 32'hEFC6_0000;

  localparam logic [IDX_W-1:0] LAST_IDX    = IDX_W'(STATE_WORDS - 1);
  localparam logic [IDX_W-1:0] STATE_END   = IDX_W'(STATE_WORDS);
  localparam logic [IDX_W:0]   OFFSET_W    = (IDX_W + 1)'(SHIFT_OFFSET);
  localparam logic [IDX_W:0]   WORDS_WIDE  = (IDX_W + 1)'(STATE_WORDS);

  // Command codes carried by an input transaction.
  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_DRAW = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_GEN_START,
    ST_GEN_FIRST,
    ST_GEN_NEXT,
    ST_GEN_FAR,
    ST_GEN_WR,
    ST_DRAW_RD,
    ST_EMIT
  } mtu_state_t;

  // One access to the state memory: an optional write and a read.
  typedef struct packed {
    logic              wr_en;
    logic [IDX_W-1:0]  wr_addr;
    logic [WORD_W-1:0] wr_data;
    logic [IDX_W-1:0]  rd_addr;
  } mtu_ram_req_t;

  // Output tempering of one state word.
  function automatic logic [WORD_W-1:0] temper(input logic [WORD_W-1:0] w);
    logic [WORD_W-1:0] r;
    r = w;
    r = r ^ (r >> 11);
    r = r ^ ((r << 7) & TEMPER_B);
    r = r ^ ((r << 15) & TEMPER_C);
    r = r ^ (r >> 18);
    return r;
  endfunction

endpackage

>>> hw/rtl/mtu_if.sv
// Input channel: one load or draw command per transaction.
interface mtu_in_if;
  logic                     valid;
  logic                     ready;
  logic                     cmd;
  logic [mtu_pkg::IDX_W-1:0]  word_index;
  logic [mtu_pkg::WORD_W-1:0] seed_word;

  modport source (output valid, output cmd, output word_index, output seed_word,
                  input ready);
  modport sink   (input valid, input cmd, input word_index, input seed_word,
                  output ready);
endinterface

// Result channel: one nonzero random word per transaction.
interface mtu_out_if;
  logic                     valid;
  logic                     ready;
  logic [mtu_pkg::WORD_W-1:0] random_word;

  modport source (output valid, output random_word, input ready);
  modport sink   (input valid, input random_word, output ready);
endinterface

>>> hw/rtl/mtu_state_ram.sv
// Generator state: one write port and one registered read port.
module mtu_state_ram (
  input  logic                       clk,
  input  mtu_pkg::mtu_ram_req_t      req,
  output logic [mtu_pkg::WORD_W-1:0] rd_data
);
  import mtu_pkg::*;

  logic [WORD_W-1:0] mem [0:STATE_WORDS-1];
  logic [WORD_W-1:0] rd_data_r;

  // Write port.
  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    rd_data_r <= mem[req.rd_addr];
  end

  assign rd_data = rd_data_r;
endmodule

>>> hw/rtl/mtu_temper.sv
// Tempering stage: registers the tempered form of the word just read.
module mtu_temper (
  input  logic                       clk,
  input  logic [mtu_pkg::WORD_W-1:0] word,
  output logic [mtu_pkg::WORD_W-1:0] tempered
);
  import mtu_pkg::*;

  logic [WORD_W-1:0] tempered_r;

  always_ff @(posedge clk) begin
    tempered_r <= temper(word);
  end

  assign tempered = tempered_r;
endmodule

>>> hw/rtl/mtu_ctrl.sv
// Sequencer: loads, in-place state regeneration and draws through the one state memory.
module mtu_ctrl (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  input  logic                       in_cmd,
  input  logic [mtu_pkg::IDX_W-1:0]  in_word_index,
  input  logic [mtu_pkg::WORD_W-1:0] in_seed_word,
  output logic                       in_ready,
  output logic                       out_valid,
  output logic [mtu_pkg::WORD_W-1:0] out_word,
  input  logic                       out_ready,
  output mtu_pkg::mtu_ram_req_t      ram_req,
  input  logic [mtu_pkg::WORD_W-1:0] rd_data,
  input  logic [mtu_pkg::WORD_W-1:0] tempered
);
  import mtu_pkg::*;

  mtu_state_t        state_r, state_nxt;
  logic [IDX_W-1:0]  k_r, k_nxt;
  logic [IDX_W-1:0]  pos_r, pos_nxt;
  logic [WORD_W-1:0] cur_r, cur_nxt;
  logic [WORD_W-1:0] nxt_r, nxt_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [WORD_W-1:0] out_word_r, out_word_nxt;

  logic              in_fire;
  logic              load_ok;
  logic              emit_ok;
  logic [IDX_W-1:0]  k_plus1;
  logic [IDX_W:0]    far_sum;
  logic [IDX_W-1:0]  far_idx;
  logic [WORD_W-1:0] mix_y;
  logic [WORD_W-1:0] twisted;

  assign in_fire = in_valid && in_ready;
  assign load_ok = in_word_index < STATE_END;
  assign emit_ok = !out_valid_r || out_ready;

  // Neighbor indexes of the word being regenerated, wrapped around the state.
  assign k_plus1 = (k_r == LAST_IDX) ? '0 : k_r + 1'b1;
  assign far_sum = {1'b0, k_r} + OFFSET_W;
  assign far_idx = (far_sum >= WORDS_WIDE) ? IDX_W'(far_sum - WORDS_WIDE)
                                           : far_sum[IDX_W-1:0];

  // Twist of one word: upper bit of word k, lower bits of word k+1.
  assign mix_y   = {cur_r[WORD_W-1], nxt_r[WORD_W-2:0]};
  assign twisted = rd_data ^ (mix_y >> 1) ^ (mix_y[0] ? MATRIX_A : '0);

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_fire && in_cmd == CMD_DRAW) begin
          state_nxt = (pos_r == STATE_END) ? ST_GEN_START : ST_DRAW_RD;
        end
      end
      ST_GEN_START: state_nxt = ST_GEN_FIRST;
      ST_GEN_FIRST: state_nxt = ST_GEN_FAR;
      ST_GEN_NEXT:  state_nxt = ST_GEN_FAR;
      ST_GEN_FAR:   state_nxt = ST_GEN_WR;
      ST_GEN_WR:    state_nxt = (k_r == LAST_IDX) ? ST_DRAW_RD : ST_GEN_NEXT;
      ST_DRAW_RD:   state_nxt = ST_EMIT;
      ST_EMIT: begin
        if (tempered == '0 || emit_ok) begin
          state_nxt = ST_IDLE;
        end
      end
      default:      state_nxt = ST_IDLE;
    endcase
  end

  // Outputs and datapath updates.
  always_comb begin
    in_ready        = 1'b0;
    ram_req.wr_en   = 1'b0;
    ram_req.wr_addr = in_word_index;
    ram_req.wr_data = in_seed_word;
    ram_req.rd_addr = pos_r;
    k_nxt           = k_r;
    pos_nxt         = pos_r;
    cur_nxt         = cur_r;
    nxt_nxt         = nxt_r;
    out_valid_nxt   = out_valid_r && !out_ready;
    out_word_nxt    = out_word_r;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_fire && in_cmd == CMD_LOAD && load_ok) begin
          ram_req.wr_en = 1'b1;
          pos_nxt       = '0;
        end
        k_nxt = '0;
      end
      ST_GEN_START: begin
        ram_req.rd_addr = '0;
      end
      ST_GEN_FIRST: begin
        cur_nxt         = rd_data;
        ram_req.rd_addr = k_plus1;
      end
      ST_GEN_NEXT: begin
        ram_req.rd_addr = k_plus1;
      end
      ST_GEN_FAR: begin
        nxt_nxt         = rd_data;
        ram_req.rd_addr = far_idx;
      end
      ST_GEN_WR: begin
        ram_req.wr_en   = 1'b1;
        ram_req.wr_addr = k_r;
        ram_req.wr_data = twisted;
        cur_nxt         = nxt_r;
        k_nxt           = k_plus1;
        // The last word done, the first fresh word is fetched for the draw.
        if (k_r == LAST_IDX) begin
          pos_nxt         = '0;
          ram_req.rd_addr = '0;
        end
      end
      ST_DRAW_RD: begin
        ram_req.rd_addr = pos_r;
        pos_nxt         = pos_r + 1'b1;
      end
      ST_EMIT: begin
        // Keep reading the drawn word so the tempered value holds while stalled.
        ram_req.rd_addr = pos_r - 1'b1;
        if (tempered != '0 && emit_ok) begin
          out_valid_nxt = 1'b1;
          out_word_nxt  = tempered;
        end
      end
      default: begin
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      pos_r       <= '0;
      k_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pos_r       <= pos_nxt;
      k_r         <= k_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    cur_r      <= cur_nxt;
    nxt_r      <= nxt_nxt;
    out_word_r <= out_word_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;
endmodule

>>> hw/rtl/mersenne_twister_uniform_top.sv
// MT19937 uniform word generator. A load transaction (cmd 0) writes seed_word
// into state word word_index and restarts the draw position; an index of 624
// or more is ignored. All 624 words must be loaded before the first draw. A
// draw transaction (cmd 1) passes through memory read and tempering, then the
// nonzero result goes to the output register, which holds it until taken
// while the next transaction is accepted. A tempered zero is consumed with no
// result. The draw after every 624th word first regenerates the whole state
// in place through the state memory, reading the two partner words of each
// word in turn and writing its twisted value back.
module mersenne_twister_uniform_top (
  input  logic      clk,
  input  logic      rst_n,
  mtu_in_if.sink    in_if,
  mtu_out_if.source out_if
);
  import mtu_pkg::*;

  mtu_ram_req_t      ram_req;
  logic [WORD_W-1:0] rd_data;
  logic [WORD_W-1:0] tempered;

  mtu_state_ram u_ram (
    .clk     (clk),
    .req     (ram_req),
    .rd_data (rd_data)
  );

  mtu_temper u_temper (
    .clk      (clk),
    .word     (rd_data),
    .tempered (tempered)
  );

  mtu_ctrl u_ctrl (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_if.valid),
    .in_cmd        (in_if.cmd),
    .in_word_index (in_if.word_index),
    .in_seed_word  (in_if.seed_word),
    .in_ready      (in_if.ready),
    .out_valid     (out_if.valid),
    .out_word      (out_if.random_word),
    .out_ready     (out_if.ready),
    .ram_req       (ram_req),
    .rd_data       (rd_data),
    .tempered      (tempered)
  );
endmodule

>>> hw/rtl/mtu_checker.sv
`include "mersenne_twister_uniform_top_defines.svh"

// Port-level checks of the generator.
module mtu_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_valid,
  input logic                       in_ready,
  input logic                       in_cmd,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic [mtu_pkg::WORD_W-1:0] random_word
);
  import mtu_pkg::*;

  // A waiting result stays offered until taken.
  `MTU_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid)
  // A result word is never zero.
  `MTU_ASSERT_NOW(a_out_nonzero, out_valid, random_word != '0)
  // A draw keeps the input closed in the following cycle.
  `MTU_ASSERT_NEXT(a_draw_busy, in_valid && in_ready && in_cmd == CMD_DRAW, !in_ready)
  // A load never creates a result.
  `MTU_ASSERT_NEXT(a_load_quiet, in_valid && in_ready && in_cmd == CMD_LOAD && !out_valid, !out_valid)
endmodule

bind mersenne_twister_uniform_top mtu_checker u_mtu_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_if.valid),
  .in_ready    (in_if.ready),
  .in_cmd      (in_if.cmd),
  .out_valid   (out_if.valid),
  .out_ready   (out_if.ready),
  .random_word (out_if.random_word)
);

>>> sim/mersenne_twister_uniform_checker.sv
`timescale 1ns / 1ps

// Watches both channels of the generator, keeps its own copy of the twister
// state and compares every result transaction with the oldest predicted word.
module mersenne_twister_uniform_checker (
  input  logic clk,
  input  logic rst_n,
  mtu_in_if    in_mon,
  mtu_out_if   out_mon,
  output int   mismatch_count,
  output int   words_pending,
  output int   words_checked,
  output int   zero_words,
  output int   regen_passes
);
  import mtu_pkg::*;

  logic [WORD_W-1:0] twister_copy [STATE_WORDS];
  int unsigned       draw_pos;
  logic [WORD_W-1:0] expected_words [$];
  int                bad_count;
  int                checked;
  int                zeros;
  int                regens;

  // Output tempering of one state word.
  function automatic logic [WORD_W-1:0] tempered_word(input logic [WORD_W-1:0] raw);
    logic [WORD_W-1:0] t;
    t = raw ^ (raw >> 11);
    t = t ^ ((t << 7) & TEMPER_B);
    t = t ^ ((t << 15) & TEMPER_C);
    return t ^ (t >> 18);
  endfunction

  // Rebuilds every state word in place, once the draw position has run out.
  function automatic void twist_all();
    logic [WORD_W-1:0] mixed;
    logic [WORD_W-1:0] fresh;
    int unsigned       k;
    for (k = 0; k < STATE_WORDS; k++) begin
      mixed = {twister_copy[k][WORD_W-1], twister_copy[(k + 1) % STATE_WORDS][WORD_W-2:0]};
      fresh = twister_copy[(k + SHIFT_OFFSET) % STATE_WORDS] ^ (mixed >> 1);
      if (mixed[0]) begin
        fresh = fresh ^ MATRIX_A;
      end
      twister_copy[k] = fresh;
    end
  endfunction

  // Applies one accepted input transaction to the state copy and queues the
  // word that it should produce, if any.
  function automatic void predict_item(input logic op, input logic [IDX_W-1:0] idx,
                                       input logic [WORD_W-1:0] seed);
    logic [WORD_W-1:0] word;
    if (op == CMD_LOAD) begin
      // Loads beyond the end of the state are dropped without effect.
      if (idx < STATE_WORDS) begin
        twister_copy[idx] = seed;
        draw_pos = 0;
      end
    end else begin
      if (draw_pos >= STATE_WORDS) begin
        twist_all();
        draw_pos = 0;
        regens++;
      end
      word = tempered_word(twister_copy[draw_pos]);
      draw_pos++;
      // A tempered zero is consumed silently.
      if (word == '0) begin
        zeros++;
      end else begin
        expected_words.push_back(word);
      end
    end
  endfunction

  // Results are compared before the new input is predicted, so a result
  // can never be matched against an expectation queued in the same cycle.
  always @(posedge clk) begin
    logic [WORD_W-1:0] want;
    if (!rst_n) begin
      expected_words.delete();
      draw_pos = 0;
    end else begin
      if (out_mon.valid === 1'b1 && out_mon.ready === 1'b1) begin
        if (expected_words.size() == 0) begin
          bad_count++;
          if (bad_count <= 10) begin
            $display("%0t: unexpected result transaction, random_word=%08h", $realtime,
                     out_mon.random_word);
          end
        end else begin
          want = expected_words.pop_front();
          checked++;
          if (out_mon.random_word !== want) begin
            bad_count++;
            if (bad_count <= 10) begin
              $display("%0t: random_word mismatch, expected %08h, got %08h", $realtime,
                       want, out_mon.random_word);
            end
          end
        end
      end
      if (in_mon.valid === 1'b1 && in_mon.ready === 1'b1) begin
        predict_item(in_mon.cmd, in_mon.word_index, in_mon.seed_word);
      end
    end
    mismatch_count <= bad_count;
    words_pending  <= expected_words.size();
    words_checked  <= checked;
    zero_words     <= zeros;
    regen_passes   <= regens;
  end

endmodule

>>> sim/mersenne_twister_uniform_top_tb.sv
`timescale 1ns / 1ps

// Drives load and draw transactions into the generator with bursty timing,
// stalls the result side on its own pattern and gives the verdict.
module mersenne_twister_uniform_top_tb;
  import mtu_pkg::*;

  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int DRAIN_CYCLES = 2000;
  localparam int RANDOM_ITEMS = 950;

  typedef enum int {RX_OPEN, RX_RANDOM, RX_CHOKE} rx_mode_t;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  mtu_in_if  in_ch ();
  mtu_out_if out_ch ();

  int mismatch_count;
  int words_pending;
  int words_checked;
  int zero_words;
  int regen_passes;

  int loads_sent;
  int loads_ignored;
  int draws_sent;
  int counted_items;
  int burst_left;

  logic     rx_ready = 1'b0;
  rx_mode_t rx_mode  = RX_OPEN;
  int       rx_hold;
  int       rx_stall;

  always #5 clk = ~clk;

  assign out_ch.ready = rx_ready;

  mersenne_twister_uniform_top dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_ch),
    .out_if (out_ch)
  );

  mersenne_twister_uniform_checker stream_check (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_mon         (in_ch),
    .out_mon        (out_ch),
    .mismatch_count (mismatch_count),
    .words_pending  (words_pending),
    .words_checked  (words_checked),
    .zero_words     (zero_words),
    .regen_passes   (regen_passes)
  );

  // The result side switches between always ready, coin-flip ready and long
  // stalls broken by single ready cycles.
  always @(posedge clk) begin
    if (rx_hold == 0) begin
      rx_mode = rx_mode_t'($urandom_range(0, 2));
      rx_hold = $urandom_range(40, 300);
    end
    rx_hold--;
    case (rx_mode)
      RX_OPEN: begin
        rx_ready <= 1'b1;
      end
      RX_RANDOM: begin
        rx_ready <= 1'($urandom_range(0, 1));
      end
      default: begin
        if (rx_stall == 0) begin
          rx_ready <= 1'b1;
          rx_stall = $urandom_range(5, 40);
        end else begin
          rx_ready <= 1'b0;
          rx_stall--;
        end
      end
    endcase
  end

  // Sends one transaction, opening a new burst after a random gap when the
  // current one is used up, and returns at the edge that accepted it.
  task automatic send_item(input logic op, input logic [IDX_W-1:0] idx,
                           input logic [WORD_W-1:0] seed);
    int   gap;
    logic taken;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 9);
      if (gap > 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_ch.valid      <= 1'b1;
    in_ch.cmd        <= op;
    in_ch.word_index <= idx;
    in_ch.seed_word  <= seed;
    // Inputs only move at rising edges, so ready seen at the falling edge
    // is what the next rising edge samples.
    taken = 1'b0;
    while (!taken) begin
      @(negedge clk);
      taken = (in_ch.ready === 1'b1);
      @(posedge clk);
    end
    if (op == CMD_DRAW) begin
      draws_sent++;
      counted_items++;
    end else if (idx < STATE_WORDS) begin
      loads_sent++;
      counted_items++;
    end else begin
      loads_ignored++;
    end
  endtask

  // A run of draws; the unused fields carry random bits.
  task automatic draw_words(input int n);
    repeat (n) send_item(CMD_DRAW, IDX_W'($urandom), $urandom);
  endtask

  // One random piece of traffic: a run of draws, a few reloads (often of
  // early words, sometimes with zero), an ignored load, or a random item.
  task automatic random_segment();
    int                pick;
    int                n;
    logic [IDX_W-1:0]  idx;
    logic [WORD_W-1:0] seed;
    pick = $urandom_range(0, 9);
    if (pick < 5) begin
      draw_words($urandom_range(1, 30));
    end else if (pick < 8) begin
      n = $urandom_range(1, 4);
      repeat (n) begin
        idx  = ($urandom_range(0, 3) == 0) ? IDX_W'($urandom_range(0, 7))
                                           : IDX_W'($urandom_range(0, STATE_WORDS - 1));
        seed = ($urandom_range(0, 7) == 0) ? '0 : $urandom;
        send_item(CMD_LOAD, idx, seed);
      end
    end else if (pick == 8) begin
      send_item(CMD_LOAD, IDX_W'($urandom_range(STATE_WORDS, 1023)), $urandom);
    end else begin
      send_item(1'($urandom_range(0, 1)), IDX_W'($urandom), $urandom);
    end
  endtask

  // Holds the sender until every predicted word has come out.
  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (words_pending != 0) @(posedge clk);
  endtask

  // Cycle watchdog.
  initial begin : watchdog
    int cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("Timeout after %0d cycles, %0d words still expected.", cycles, words_pending);
    $display("** mersenne_twister_uniform_top: FAILED **");
    $finish;
  end

  initial begin : stimulus
    int i;
    in_ch.valid      <= 1'b0;
    in_ch.cmd        <= CMD_LOAD;
    in_ch.word_index <= '0;
    in_ch.seed_word  <= '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // The whole state is seeded before anything is drawn.
    for (i = 0; i < STATE_WORDS; i++) begin
      send_item(CMD_LOAD, IDX_W'(i), $urandom);
    end

    // A zero word tempers to zero and must be skipped.
    send_item(CMD_LOAD, '0, '0);
    draw_words(2);
    // Out-of-range indexes, at the top of the field and just past the end.
    send_item(CMD_LOAD, '1, '1);
    draw_words(1);
    send_item(CMD_LOAD, STATE_END, '0);
    draw_words(1);
    // Extreme seed values, at the edges of the state and at word 512.
    send_item(CMD_LOAD, LAST_IDX, '1);
    send_item(CMD_LOAD, IDX_W'(512), 32'h8000_0000);
    send_item(CMD_LOAD, IDX_W'(1), 32'h0000_0001);
    draw_words(3);
    send_item(CMD_LOAD, '0, $urandom);
    draw_words(1);

    // Random traffic, with one long run of draws that forces a regeneration.
    counted_items = 0;
    while (counted_items < 150) random_segment();
    draw_words(660);
    wait_drained();
    while (counted_items < RANDOM_ITEMS) random_segment();

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d loads (%0d with an out-of-range index) and %0d draws; %0d regenerations.",
             loads_sent + loads_ignored, loads_ignored, draws_sent, regen_passes);
    $display("Compared %0d random words; %0d tempered zero words were skipped.",
             words_checked, zero_words);
    if (mismatch_count == 0) begin
      $display("** mersenne_twister_uniform_top: PASSED **");
    end else begin
      $display("%0d mismatches.", mismatch_count);
      $display("** mersenne_twister_uniform_top: FAILED **");
    end
    $finish;
  end

endmodule
